// ----- rtl/jteh_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jteh_pkg
// Shared types and constants for the jet tag efficiency histogrammer.
// ---------------------------------------------------------------------------
package jteh_pkg;

  // result status codes
  localparam logic [2:0] ST_STORED   = 3'd0;
  localparam logic [2:0] ST_COUNTED  = 3'd1;
  localparam logic [2:0] ST_REJECTED = 3'd2;
  localparam logic [2:0] ST_DROPPED  = 3'd3;
  localparam logic [2:0] ST_READ     = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_SELECT = 2'd0;
  localparam logic [1:0] REG_TIGHT  = 2'd1;
  localparam logic [1:0] REG_MEDIUM = 2'd2;
  localparam logic [1:0] REG_LOOSE  = 2'd3;

  // select modes
  localparam logic [1:0] SEL_LEAD   = 2'd1;
  localparam logic [1:0] SEL_SECOND = 2'd2;

  // flavor codes
  localparam logic [2:0] FLV_LIGHT  = 3'd0;
  localparam logic [2:0] FLV_CHARM  = 3'd4;
  localparam logic [2:0] FLV_BOTTOM = 3'd5;

  localparam logic [15:0] TAG_PT_MIN  = 16'd320;
  localparam logic [12:0] TAG_ETA_MAX = 13'd2400;
  localparam int unsigned ETA_STEP    = 400;
  localparam int unsigned PT_TAB_LAST = 17;
  localparam int unsigned PT_EXTRA    = 3200;

  // request operations
  localparam logic OP_JET  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // pt edge i in 1/16 GeV, 32 bits so that extended edges do not wrap
  function automatic logic [31:0] pt_edge(input int unsigned i);
    logic [31:0] e;
    case (i)
      0: e = 32'd320;    1: e = 32'd400;    2: e = 32'd480;
      3: e = 32'd560;    4: e = 32'd640;    5: e = 32'd720;
      6: e = 32'd800;    7: e = 32'd960;    8: e = 32'd1120;
      9: e = 32'd1280;   10: e = 32'd1440;  11: e = 32'd1600;
      12: e = 32'd1920;  13: e = 32'd2400;  14: e = 32'd3200;
      15: e = 32'd4800;  16: e = 32'd6400;  17: e = 32'd9600;
      default: e = 32'(9600 + (i - PT_TAB_LAST) * PT_EXTRA);
    endcase
    return e;
  endfunction

  // controller to datapath commands
  typedef struct packed {
    logic clear_event;   // reset event trackers
    logic store_jet;     // buffer incoming jet
    logic mark_ovf;      // set overflow flag
    logic start_scan;    // reset scan index and fill counts
    logic load_jet;      // read buffer at scan index
    logic prep_jet;      // classify loaded jet
    logic rd_cnt;        // issue counter read
    logic wr_cnt;        // write incremented counter, advance kind
    logic next_jet;      // advance scan index
    logic start_read;    // issue counter read for a read request
    logic clr_step;      // clearing pass write
    logic load_result;   // capture result
    logic [2:0] status;
  } jteh_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic full;          // buffer is full
    logic ovf;           // overflow flag (including this request)
    logic few_tag;       // fewer than two taggable jets
    logic scan_done;     // scan index reached jets held
    logic jet_fill;      // loaded jet is selected and good flavor
    logic kind_done;     // no more kinds to fill for this jet
    logic clr_done;      // clearing pass at last entry
  } jteh_sts_t;

endpackage

// ----- rtl/jet_tag_efficiency_histogrammer.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jet_tag_efficiency_histogrammer
// Buffers the jets of an event and fills b-tag efficiency counters.
// ---------------------------------------------------------------------------
// A jet request that does not end an event is answered from the idle state. A
// counter read passes through a read state and an output state. The request
// carrying the last jet of a counted event runs a scan over the buffer: each
// held jet is loaded, prepared and classified, and each jet that fills steps
// through its counter increments, each a read then a write on the single
// counter memory port. After reset a clearing pass zeroes the counter memory
// one entry a cycle, all 12*(PT_BINS+2)*(ETA_BINS+2) entries (2052 by
// default), during which no request is taken. Configuration writes are taken
// at any time.
module jet_tag_efficiency_histogrammer import jteh_pkg::*; #(
  parameter int MAX_JETS    = 16,
  parameter int PT_BINS     = 17,
  parameter int ETA_BINS    = 7,
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [15:0] jet_pt_i,
  input  logic [12:0] jet_abs_eta_i,
  input  logic [2:0]  jet_flavor_i,
  input  logic [15:0] jet_score_i,
  input  logic        last_jet_i,
  input  logic [1:0]  read_flavor_i,
  input  logic [1:0]  read_kind_i,
  input  logic [4:0]  read_pt_bin_i,
  input  logic [3:0]  read_eta_bin_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [6:0]  fills_done_o,
  output logic [4:0]  bad_flavor_jets_o,
  output logic [31:0] counter_value_o
);

  logic [1:0]  select_mode_q;
  logic [15:0] tight_q, medium_q, loose_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      select_mode_q <= '0;
      tight_q       <= '0;
      medium_q      <= '0;
      loose_q       <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SELECT: select_mode_q <= cfg_data_i[1:0];
        REG_TIGHT:  tight_q       <= cfg_data_i;
        REG_MEDIUM: medium_q      <= cfg_data_i;
        REG_LOOSE:  loose_q       <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  jteh_cmd_t cmd;
  jteh_sts_t sts;

  jteh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .last_jet_i  (last_jet_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  jteh_datapath #(
    .MAX_JETS    (MAX_JETS),
    .PT_BINS     (PT_BINS),
    .ETA_BINS    (ETA_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .select_mode_i     (select_mode_q),
    .tight_i           (tight_q),
    .medium_i          (medium_q),
    .loose_i           (loose_q),
    .jet_pt_i          (jet_pt_i),
    .jet_abs_eta_i     (jet_abs_eta_i),
    .jet_flavor_i      (jet_flavor_i),
    .jet_score_i       (jet_score_i),
    .read_flavor_i     (read_flavor_i),
    .read_kind_i       (read_kind_i),
    .read_pt_bin_i     (read_pt_bin_i),
    .read_eta_bin_i    (read_eta_bin_i),
    .status_o          (status_o),
    .fills_done_o      (fills_done_o),
    .bad_flavor_jets_o (bad_flavor_jets_o),
    .counter_value_o   (counter_value_o)
  );

endmodule

// ----- rtl/jteh_datapath.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jteh_datapath
// Jet buffer, score trackers, binning and the histogram counter memory.
// ---------------------------------------------------------------------------
module jteh_datapath import jteh_pkg::*; #(
  parameter int MAX_JETS    = 16,
  parameter int PT_BINS     = 17,
  parameter int ETA_BINS    = 7,
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  jteh_cmd_t   cmd_i,
  output jteh_sts_t   sts_o,
  input  logic [1:0]  select_mode_i,
  input  logic [15:0] tight_i,
  input  logic [15:0] medium_i,
  input  logic [15:0] loose_i,
  input  logic [15:0] jet_pt_i,
  input  logic [12:0] jet_abs_eta_i,
  input  logic [2:0]  jet_flavor_i,
  input  logic [15:0] jet_score_i,
  input  logic [1:0]  read_flavor_i,
  input  logic [1:0]  read_kind_i,
  input  logic [4:0]  read_pt_bin_i,
  input  logic [3:0]  read_eta_bin_i,
  output logic [2:0]  status_o,
  output logic [6:0]  fills_done_o,
  output logic [4:0]  bad_flavor_jets_o,
  output logic [31:0] counter_value_o
);

  localparam int N_PT   = PT_BINS + 2;
  localparam int N_ETA  = ETA_BINS + 2;
  localparam int N_CNT  = 12 * N_PT * N_ETA;
  localparam int AW     = $clog2(N_CNT);
  localparam int JW     = $clog2(MAX_JETS);
  localparam int HW     = $clog2(MAX_JETS + 1);
  localparam int PBW    = $clog2(N_PT);
  localparam int EBW    = $clog2(N_ETA);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  // jet buffer
  logic [47:0] jbuf [MAX_JETS];
  logic [HW-1:0] held_q;
  logic          ovf_q;
  logic [HW-1:0] tag_q;
  logic          lead_v_q, sec_v_q;
  logic [15:0]   lead_s_q, sec_s_q;
  logic [JW-1:0] lead_i_q, sec_i_q;

  logic full, taggable;
  assign full     = (held_q == HW'(MAX_JETS));
  assign taggable = (jet_pt_i > TAG_PT_MIN) && (jet_abs_eta_i < TAG_ETA_MAX);

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_jet) begin
      jbuf[held_q[JW-1:0]] <= {jet_pt_i, jet_abs_eta_i, jet_flavor_i, jet_score_i};
    end
  end

  // event trackers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0; ovf_q <= 1'b0; tag_q <= '0;
      lead_v_q <= 1'b0; sec_v_q <= 1'b0;
      lead_s_q <= '0; sec_s_q <= '0; lead_i_q <= '0; sec_i_q <= '0;
    end else if (cmd_i.clear_event) begin
      held_q <= '0; ovf_q <= 1'b0; tag_q <= '0;
      lead_v_q <= 1'b0; sec_v_q <= 1'b0;
    end else begin
      if (cmd_i.mark_ovf) ovf_q <= 1'b1;
      if (cmd_i.store_jet) begin
        held_q <= held_q + 1'b1;
        if (taggable) tag_q <= tag_q + 1'b1;
        if (!lead_v_q || jet_score_i > lead_s_q) begin
          sec_v_q  <= lead_v_q; sec_s_q <= lead_s_q; sec_i_q <= lead_i_q;
          lead_v_q <= 1'b1; lead_s_q <= jet_score_i; lead_i_q <= held_q[JW-1:0];
        end else if (!sec_v_q || jet_score_i > sec_s_q) begin
          sec_v_q <= 1'b1; sec_s_q <= jet_score_i; sec_i_q <= held_q[JW-1:0];
        end
      end
    end
  end

  // taggable count after the current jet
  logic [HW-1:0] tag_next;
  assign tag_next = tag_q + HW'(cmd_i.store_jet && taggable);

  // scan over the buffer
  logic [HW-1:0] scan_q;
  logic [47:0]   ld_q;
  logic [6:0]    fills_q;
  logic [4:0]    bad_q;
  logic [1:0]    fl_q;
  logic [PBW-1:0] pb_q;
  logic [EBW-1:0] eb_q;
  logic [3:0]    kmask_q;   // kinds still to fill
  logic [1:0]    kind_q;
  logic          fill_q;

  logic [15:0] l_pt, l_score;
  logic [12:0] l_eta;
  logic [2:0]  l_flv;
  assign {l_pt, l_eta, l_flv, l_score} = ld_q;

  logic sel_ok, flv_ok;
  logic [1:0] fl_code;
  always_comb begin
    sel_ok = 1'b1;
    if (select_mode_i == SEL_LEAD)
      sel_ok = lead_v_q && (scan_q[JW-1:0] == lead_i_q);
    else if (select_mode_i == SEL_SECOND)
      sel_ok = sec_v_q && (scan_q[JW-1:0] == sec_i_q);
    flv_ok  = 1'b1;
    fl_code = 2'd0;
    case (l_flv)
      FLV_LIGHT:  fl_code = 2'd0;
      FLV_CHARM:  fl_code = 2'd1;
      FLV_BOTTOM: fl_code = 2'd2;
      default:    flv_ok  = 1'b0;
    endcase
  end

  // binning: independent compares against constant edges
  logic [PBW-1:0] pb_c;
  logic [EBW-1:0] eb_c;
  always_comb begin
    pb_c = PBW'(PT_BINS + 1);
    for (int i = PT_BINS; i >= 1; i--) begin
      if (32'(l_pt) < pt_edge(i)) pb_c = PBW'(i);
    end
    if (32'(l_pt) < pt_edge(0)) pb_c = '0;
    eb_c = EBW'(ETA_BINS + 1);
    for (int i = ETA_BINS; i >= 1; i--) begin
      if (32'(l_eta) < 32'(ETA_STEP * i)) eb_c = EBW'(i);
    end
  end

  // next kind to fill
  logic [1:0] kind_nx;
  always_comb begin
    kind_nx = 2'd0;
    for (int k = 3; k >= 0; k--) begin
      if (kmask_q[k]) kind_nx = 2'(k);
    end
  end

  // counter memory, clearing pass address
  logic [COUNT_WIDTH-1:0] mem [N_CNT];
  logic [AW-1:0] clr_q;
  logic [AW-1:0] addr_q;
  logic [COUNT_WIDTH-1:0] rd_q;
  logic rd_ok_q;

  logic [AW-1:0] fill_addr, read_addr;
  logic read_ok;
  assign fill_addr = AW'(((32'(fl_q) * 4 + 32'(kind_nx)) * N_PT + 32'(pb_q)) * N_ETA
                         + 32'(eb_q));
  assign read_ok   = (read_flavor_i < 2'd3) && (32'(read_pt_bin_i) < N_PT) &&
                     (32'(read_eta_bin_i) < N_ETA);
  assign read_addr = AW'(((32'(read_flavor_i) * 4 + 32'(read_kind_i)) * N_PT +
                         32'(read_pt_bin_i)) * N_ETA + 32'(read_eta_bin_i));

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) mem[clr_q] <= '0;
    else if (cmd_i.wr_cnt && rd_q != CNT_MAX) mem[addr_q] <= rd_q + 1'b1;
    if (cmd_i.rd_cnt) begin
      rd_q <= mem[fill_addr];
      addr_q <= fill_addr;
    end else if (cmd_i.start_read) begin
      rd_q <= mem[read_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_read) rd_ok_q <= read_ok;
    if (cmd_i.start_scan) begin
      scan_q <= '0; fills_q <= '0; bad_q <= '0;
    end
    if (cmd_i.load_jet) ld_q <= jbuf[scan_q[JW-1:0]];
    if (cmd_i.prep_jet) begin
      fl_q    <= fl_code;
      pb_q    <= pb_c;
      eb_q    <= eb_c;
      fill_q  <= sel_ok && flv_ok;
      kmask_q <= {l_score > loose_i, l_score > medium_i, l_score > tight_i, 1'b1};
      if (sel_ok && !flv_ok) bad_q <= bad_q + 1'b1;
    end
    if (cmd_i.rd_cnt) kind_q <= kind_nx;
    if (cmd_i.wr_cnt) begin
      kmask_q[kind_q] <= 1'b0;
      fills_q <= fills_q + 1'b1;
    end
    if (cmd_i.next_jet) scan_q <= scan_q + 1'b1;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      status_o          <= cmd_i.status;
      fills_done_o      <= (cmd_i.status == ST_COUNTED) ? fills_q : '0;
      bad_flavor_jets_o <= (cmd_i.status == ST_COUNTED) ? bad_q : '0;
      counter_value_o   <= (cmd_i.status == ST_READ && rd_ok_q) ? 32'(rd_q) : '0;
    end
  end

  assign sts_o.full      = full;
  assign sts_o.ovf       = ovf_q || full;
  assign sts_o.few_tag   = (tag_next < HW'(2));
  assign sts_o.scan_done = (scan_q == held_q);
  assign sts_o.jet_fill  = fill_q;
  assign sts_o.kind_done = (kmask_q == 4'd0);
  assign sts_o.clr_done  = (clr_q == AW'(N_CNT - 1));

endmodule

// ----- rtl/jteh_ctrl.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jteh_ctrl
// Sequencer: request intake, event fill scan, counter reads, result handoff.
// ---------------------------------------------------------------------------
module jteh_ctrl import jteh_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  logic      operation_i,
  input  logic      last_jet_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output jteh_cmd_t cmd_o,
  input  jteh_sts_t sts_i
);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_LOAD  = 10'b0000000100,
    S_PREP  = 10'b0000001000,
    S_CLASS = 10'b0000010000,
    S_RD    = 10'b0000100000,
    S_WR    = 10'b0001000000,
    S_DONE  = 10'b0010000000,
    S_READ  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;
  logic   free;

  // the result register can take a new result this cycle
  assign free        = !ovalid_q || !out_stall_i;
  assign in_stall_o  = !(state_q == S_IDLE && free);
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d  = state_q;
    ovalid_d = ovalid_q && out_stall_i;
    cmd_o    = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i && free) begin
          cmd_o.load_result = 1'b1;
          ovalid_d = 1'b1;
          if (operation_i == OP_READ) begin
            cmd_o.start_read  = 1'b1;
            cmd_o.load_result = 1'b0;
            ovalid_d          = ovalid_q && out_stall_i;
            state_d           = S_READ;
          end else begin
            cmd_o.store_jet = !sts_i.full;
            cmd_o.mark_ovf  = sts_i.full;
            if (sts_i.ovf) begin
              cmd_o.status      = ST_DROPPED;
              cmd_o.clear_event = last_jet_i;
            end else if (!last_jet_i) begin
              cmd_o.status = ST_STORED;
            end else if (sts_i.few_tag) begin
              cmd_o.status      = ST_REJECTED;
              cmd_o.clear_event = 1'b1;
            end else begin
              cmd_o.load_result = 1'b0;
              ovalid_d          = ovalid_q && out_stall_i;
              cmd_o.start_scan  = 1'b1;
              state_d           = S_LOAD;
            end
          end
        end
      end
      S_LOAD: begin
        if (sts_i.scan_done) state_d = S_DONE;
        else begin
          cmd_o.load_jet = 1'b1;
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep_jet = 1'b1;
        state_d = S_CLASS;
      end
      S_CLASS: begin
        if (sts_i.jet_fill) state_d = S_RD;
        else begin
          cmd_o.next_jet = 1'b1;
          state_d = S_LOAD;
        end
      end
      S_RD: begin
        if (sts_i.kind_done) begin
          cmd_o.next_jet = 1'b1;
          state_d = S_LOAD;
        end else begin
          cmd_o.rd_cnt = 1'b1;
          state_d = S_WR;
        end
      end
      S_WR: begin
        cmd_o.wr_cnt = 1'b1;
        state_d = S_RD;
      end
      S_DONE: begin
        if (free) begin
          cmd_o.load_result = 1'b1;
          cmd_o.status      = ST_COUNTED;
          cmd_o.clear_event = 1'b1;
          ovalid_d          = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_READ: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (free) begin
          cmd_o.load_result = 1'b1;
          cmd_o.status      = ST_READ;
          ovalid_d          = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule
